/* design/emt_pkg.sv */
package emt_pkg;

  // Data and coefficient formats
  localparam int D_W         = 24;          // Q16.8 coordinates, angle units
  localparam int ALPHA_W     = 17;          // Q0.16 weight, one bit of headroom for 1.0
  localparam int ALPHA_SHIFT = 16;
  localparam int ALPHA_ONE   = 1 << ALPHA_SHIFT;
  localparam int ANG_W       = 17;          // wrapped angle
  localparam int ANGLE_TURN  = 92160;       // 360 degrees in Q.8

  // Reset weights: 1.0 for position/angle, 0.08 for the derivative stages
  localparam logic [ALPHA_W-1:0] POS_ALPHA_RST = ALPHA_W'(ALPHA_ONE);
  localparam logic [ALPHA_W-1:0] DER_ALPHA_RST = ALPHA_W'(5243);

  // Configuration port
  localparam int CFG_AW = 3;

  // EMA datapath widths
  localparam int N_W    = D_W + 2;             // EMA operands
  localparam int DIFF_W = N_W + 1;
  localparam int PROD_W = DIFF_W + ALPHA_W + 1;
  localparam int EW     = D_W + 4;             // EMA result before saturation

  // One turn = 2^TURN_SHIFT * TURN_ODD
  localparam int TURN_SHIFT = 11;
  localparam int TURN_ODD   = ANGLE_TURN >> TURN_SHIFT;
  localparam int Q_W        = D_W - TURN_SHIFT;
  localparam int Q_BIAS     = TURN_ODD * ((1 << (Q_W - 1)) / TURN_ODD + 1);
  localparam int U_W        = Q_W + 1;
  localparam int RECIP      = (1 << 16) / TURN_ODD;
  localparam int RECIP_W    = $clog2(RECIP + 1);
  localparam int RO_W       = ANG_W - TURN_SHIFT;
  localparam int AD_W       = ANG_W + 2;

  typedef enum logic [1:0] {
    CNT_NONE,
    CNT_ONE,
    CNT_MANY
  } cnt_t;

  typedef struct packed {
    logic signed [D_W-1:0] meas_x;
    logic signed [D_W-1:0] meas_y;
    logic signed [D_W-1:0] meas_angle;
  } meas_t;

  typedef struct packed {
    logic signed [D_W-1:0] filt_x;
    logic signed [D_W-1:0] filt_y;
    logic signed [D_W-1:0] filt_angle;
    logic signed [D_W-1:0] vel_x;
    logic signed [D_W-1:0] vel_y;
    logic signed [D_W-1:0] vel_ang;
    logic signed [D_W-1:0] acc_x;
    logic signed [D_W-1:0] acc_y;
    logic signed [D_W-1:0] acc_ang;
    logic signed [D_W-1:0] pred_x;
    logic signed [D_W-1:0] pred_y;
    logic [ANG_W-1:0]      pred_angle;
  } result_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] pos;
    logic [ALPHA_W-1:0] ang;
    logic [ALPHA_W-1:0] vel;
    logic [ALPHA_W-1:0] ang_vel;
    logic [ALPHA_W-1:0] acc;
    logic [ALPHA_W-1:0] ang_acc;
  } alpha_t;

  typedef struct packed {
    logic signed [D_W-1:0] x;
    logic signed [D_W-1:0] y;
    logic [ANG_W-1:0]      ang;
  } raw_t;

  typedef struct packed {
    raw_t                  raw;
    logic signed [D_W-1:0] rv_x;
    logic signed [D_W-1:0] rv_y;
    logic signed [D_W-1:0] rv_ang;
    logic signed [D_W:0]   da_x;
    logic signed [D_W:0]   da_y;
    logic signed [D_W:0]   da_ang;
    cnt_t                  cnt;
  } diff_t;

  typedef struct packed {
    logic signed [D_W-1:0] fx;
    logic signed [D_W-1:0] fy;
    logic signed [D_W-1:0] fa;
    logic signed [D_W-1:0] vx;
    logic signed [D_W-1:0] vy;
    logic signed [D_W-1:0] va;
    logic signed [D_W-1:0] ax;
    logic signed [D_W-1:0] ay;
    logic signed [D_W-1:0] aa;
  } filt_t;

  // Saturate an EMA-width value to the data width
  function automatic logic signed [D_W-1:0] sat_d(input logic signed [EW-1:0] v);
    if (v[EW-1:D_W-1] == {(EW-D_W+1){v[EW-1]}}) begin
      return v[D_W-1:0];
    end
    return v[EW-1] ? {1'b1, {(D_W-1){1'b0}}} : {1'b0, {(D_W-1){1'b1}}};
  endfunction

  // v mod ANGLE_TURN into [0, turn): low bits pass, the odd factor goes
  // through a reciprocal multiply with one correction step
  function automatic logic [ANG_W-1:0] wrap_turn(input logic signed [D_W-1:0] v);
    logic signed [Q_W-1:0]    q;
    logic [U_W-1:0]           u;
    logic [U_W+RECIP_W-1:0]   prod;
    logic [U_W-1:0]           qe;
    logic [U_W-1:0]           r;
    q    = v[D_W-1:TURN_SHIFT];
    u    = U_W'(int'(q) + Q_BIAS);
    prod = u * RECIP_W'(RECIP);
    qe   = U_W'(prod >> 16);
    r    = u - U_W'(int'(qe) * TURN_ODD);
    if (r >= U_W'(TURN_ODD)) begin
      r = r - U_W'(TURN_ODD);
    end
    return {r[RO_W-1:0], v[TURN_SHIFT-1:0]};
  endfunction

  // Shortest signed difference, in (-turn/2, turn/2]
  function automatic logic signed [D_W-1:0] ang_diff(input logic [ANG_W-1:0] from_a,
                                                     input logic [ANG_W-1:0] to_a);
    logic signed [AD_W-1:0] d;
    d = $signed(AD_W'(to_a)) - $signed(AD_W'(from_a));
    if (2 * int'(d) > ANGLE_TURN) begin
      d = d - $signed(AD_W'(ANGLE_TURN));
    end else if (2 * int'(d) <= -ANGLE_TURN) begin
      d = d + $signed(AD_W'(ANGLE_TURN));
    end
    return D_W'(d);
  endfunction

  // o + round_half_up(a * (n - o) / ONE), weight clamped to 1.0
  function automatic logic signed [EW-1:0] ema(input logic [ALPHA_W-1:0] alpha,
                                               input logic signed [N_W-1:0] nv,
                                               input logic signed [N_W-1:0] ov);
    logic [ALPHA_W-1:0]        a;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [PROD_W-1:0]  prod;
    logic signed [EW-1:0]      step;
    a    = (alpha > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : alpha;
    diff = DIFF_W'(nv) - DIFF_W'(ov);
    prod = $signed({1'b0, a}) * diff;
    prod = prod + $signed(PROD_W'(ALPHA_ONE / 2));
    step = EW'(prod >>> ALPHA_SHIFT);
    return EW'(ov) + step;
  endfunction

endpackage

/* design/emt_stream_if.sv */
interface emt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/emt_diff.sv */
module emt_diff (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  emt_pkg::raw_t raw_i,
  output emt_pkg::diff_t diff_o
);
  import emt_pkg::*;

  // diff_r doubles as the raw history: last raw sample and raw velocity
  diff_t diff_r, diff_nxt;
  cnt_t  cnt_r, cnt_nxt;

  always_comb begin
    diff_nxt     = '0;
    diff_nxt.raw = raw_i;
    diff_nxt.cnt = cnt_r;
    if (cnt_r != CNT_NONE) begin
      diff_nxt.rv_x   = sat_d(EW'(raw_i.x) - EW'(diff_r.raw.x));
      diff_nxt.rv_y   = sat_d(EW'(raw_i.y) - EW'(diff_r.raw.y));
      diff_nxt.rv_ang = ang_diff(diff_r.raw.ang, raw_i.ang);
    end
    diff_nxt.da_x   = (D_W+1)'(diff_nxt.rv_x) - (D_W+1)'(diff_r.rv_x);
    diff_nxt.da_y   = (D_W+1)'(diff_nxt.rv_y) - (D_W+1)'(diff_r.rv_y);
    diff_nxt.da_ang = (D_W+1)'(diff_nxt.rv_ang) - (D_W+1)'(diff_r.rv_ang);

    case (cnt_r)
      CNT_NONE: cnt_nxt = CNT_ONE;
      CNT_ONE:  cnt_nxt = CNT_MANY;
      default:  cnt_nxt = CNT_MANY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= CNT_NONE;
      diff_r <= '0;
    end else if (load) begin
      cnt_r  <= cnt_nxt;
      diff_r <= diff_nxt;
    end
  end

  assign diff_o = diff_r;

endmodule

/* design/emt_filter.sv */
module emt_filter (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  emt_pkg::alpha_t alpha,
  input  emt_pkg::diff_t  diff_i,
  output emt_pkg::filt_t  filt_o
);
  import emt_pkg::*;

  // filt_r is both the stage output and the recursive EMA state
  filt_t filt_r, filt_nxt;

  always_comb begin
    filt_nxt = '0;
    case (diff_i.cnt)
      CNT_NONE: begin
        filt_nxt.fx = diff_i.raw.x;
        filt_nxt.fy = diff_i.raw.y;
        filt_nxt.fa = D_W'(diff_i.raw.ang);
      end
      CNT_ONE: begin
        filt_nxt.fx = D_W'(ema(alpha.pos, N_W'(diff_i.raw.x), N_W'(filt_r.fx)));
        filt_nxt.fy = D_W'(ema(alpha.pos, N_W'(diff_i.raw.y), N_W'(filt_r.fy)));
        filt_nxt.fa = D_W'(ema(alpha.ang, N_W'(diff_i.raw.ang), N_W'(filt_r.fa)));
        filt_nxt.vx = diff_i.rv_x;
        filt_nxt.vy = diff_i.rv_y;
        filt_nxt.va = diff_i.rv_ang;
      end
      default: begin
        filt_nxt.fx = D_W'(ema(alpha.pos, N_W'(diff_i.raw.x), N_W'(filt_r.fx)));
        filt_nxt.fy = D_W'(ema(alpha.pos, N_W'(diff_i.raw.y), N_W'(filt_r.fy)));
        filt_nxt.fa = D_W'(ema(alpha.ang, N_W'(diff_i.raw.ang), N_W'(filt_r.fa)));
        filt_nxt.vx = sat_d(ema(alpha.vel, N_W'(diff_i.rv_x), N_W'(filt_r.vx)));
        filt_nxt.vy = sat_d(ema(alpha.vel, N_W'(diff_i.rv_y), N_W'(filt_r.vy)));
        filt_nxt.va = sat_d(ema(alpha.ang_vel, N_W'(diff_i.rv_ang), N_W'(filt_r.va)));
        filt_nxt.ax = sat_d(ema(alpha.acc, N_W'(diff_i.da_x), N_W'(filt_r.ax)));
        filt_nxt.ay = sat_d(ema(alpha.acc, N_W'(diff_i.da_y), N_W'(filt_r.ay)));
        filt_nxt.aa = sat_d(ema(alpha.ang_acc, N_W'(diff_i.da_ang), N_W'(filt_r.aa)));
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= '0;
    end else if (load) begin
      filt_r <= filt_nxt;
    end
  end

  assign filt_o = filt_r;

endmodule

/* design/ema_motion_tracker.sv */
// Channel   Dir  Payload                                      Beat when
// in_if     in   meas_x, meas_y, meas_angle                   valid & ready
// out_if    out  filt/vel/acc x,y,angle; pred_x/y/angle       valid & ready
// cfg_*     in   cfg_addr selects one of six alphas           cfg_we
//
// One beat per cycle sustained while the output is not stalled; five register
// stages lie between an input beat and out_valid.
// The rate is set by the filter stage, where the three EMA updates per axis
// close their feedback through the filt_r register alone (one 18x27 multiply each).
// Every stage has its own valid and moves whenever the next one is free, so
// an output stall only stops the input once all five stages are full.
// rst_n is synchronous; it clears valids, sample count and history and
// reloads the default alphas.
module ema_motion_tracker (
  input  logic                         clk,
  input  logic                         rst_n,
  emt_stream_if.sink                   in_if,
  emt_stream_if.source                 out_if,
  input  logic                         cfg_we,
  input  logic [emt_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [emt_pkg::ALPHA_W-1:0]  cfg_wdata
);
  import emt_pkg::*;

  typedef enum logic [CFG_AW-1:0] {
    CFG_POS_ALPHA,
    CFG_ANG_ALPHA,
    CFG_VEL_ALPHA,
    CFG_ANG_VEL_ALPHA,
    CFG_ACC_ALPHA,
    CFG_ANG_ACC_ALPHA
  } cfg_idx_t;

  alpha_t  alpha_r;
  meas_t   meas_r;
  raw_t    raw_r, raw_nxt;
  diff_t   diff;
  filt_t   filt;
  result_t out_r, out_nxt;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic signed [EW-1:0] sum_x, sum_y, sum_a;

  // Config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r.pos     <= POS_ALPHA_RST;
      alpha_r.ang     <= POS_ALPHA_RST;
      alpha_r.vel     <= DER_ALPHA_RST;
      alpha_r.ang_vel <= DER_ALPHA_RST;
      alpha_r.acc     <= DER_ALPHA_RST;
      alpha_r.ang_acc <= DER_ALPHA_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_POS_ALPHA:     alpha_r.pos     <= cfg_wdata;
        CFG_ANG_ALPHA:     alpha_r.ang     <= cfg_wdata;
        CFG_VEL_ALPHA:     alpha_r.vel     <= cfg_wdata;
        CFG_ANG_VEL_ALPHA: alpha_r.ang_vel <= cfg_wdata;
        CFG_ACC_ALPHA:     alpha_r.acc     <= cfg_wdata;
        CFG_ANG_ACC_ALPHA: alpha_r.ang_acc <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage flow control
  assign rdy5 = !v5_r || out_if.ready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_if.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_if.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // Stage 1: input register; stage 2: angle wrapped into one turn
  always_comb begin
    raw_nxt.x   = meas_r.meas_x;
    raw_nxt.y   = meas_r.meas_y;
    raw_nxt.ang = wrap_turn(meas_r.meas_angle);
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && rdy1) meas_r <= in_if.data;
    if (v1_r && rdy2)        raw_r  <= raw_nxt;
  end

  // Stage 3: raw velocity and its change
  emt_diff u_diff (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (v2_r && rdy3),
    .raw_i  (raw_r),
    .diff_o (diff)
  );

  // Stage 4: EMA state
  emt_filter u_filter (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (v3_r && rdy4),
    .alpha  (alpha_r),
    .diff_i (diff),
    .filt_o (filt)
  );

  // Stage 5: prediction f + v + round_half_up(a/2); on the first sample v, a are 0
  always_comb begin
    sum_x = EW'(filt.fx) + EW'(filt.vx) + ((EW'(filt.ax) + EW'(1)) >>> 1);
    sum_y = EW'(filt.fy) + EW'(filt.vy) + ((EW'(filt.ay) + EW'(1)) >>> 1);
    sum_a = EW'(filt.fa) + EW'(filt.va) + ((EW'(filt.aa) + EW'(1)) >>> 1);

    out_nxt.filt_x     = filt.fx;
    out_nxt.filt_y     = filt.fy;
    out_nxt.filt_angle = filt.fa;
    out_nxt.vel_x      = filt.vx;
    out_nxt.vel_y      = filt.vy;
    out_nxt.vel_ang    = filt.va;
    out_nxt.acc_x      = filt.ax;
    out_nxt.acc_y      = filt.ay;
    out_nxt.acc_ang    = filt.aa;
    out_nxt.pred_x     = sat_d(sum_x);
    out_nxt.pred_y     = sat_d(sum_y);
    // angle sum stays well inside the data width, so no saturation before the wrap
    out_nxt.pred_angle = wrap_turn(sum_a[D_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (v4_r && rdy5) out_r <= out_nxt;
  end

  assign out_if.valid = v5_r;
  assign out_if.data  = out_r;

endmodule

/* design/emt_checker.sv */
module emt_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input emt_pkg::result_t out_data
);
  import emt_pkg::*;

  localparam int DEPTH = 5;
  localparam int OCC_W = $clog2(DEPTH + 1);

  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic in_beat, out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_comb begin
    occ_nxt = occ_r;
    if (in_beat && !out_beat) occ_nxt = occ_r + OCC_W'(1);
    if (!in_beat && out_beat) occ_nxt = occ_r - OCC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // No result without an item in flight
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> occ_r != '0)
    else $error("output beat with nothing in flight");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(DEPTH))
    else $error("more items in flight than pipeline stages");

  // Input backpressure only when every stage is full and the output is stalled
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready && occ_r == OCC_W'(DEPTH))
    else $error("input stalled while pipeline has room");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

endmodule

bind ema_motion_tracker emt_checker u_emt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);

/* bench/tb_top.sv */
module tb_top;
  import emt_pkg::*;

  localparam int     N_ALPHAS        = 6;
  localparam int     ITEMS_PER_PHASE = 100;
  localparam int     HOLD_CYCLES     = 48;
  localparam int     DRAIN_PAD       = 8;
  localparam int     QUIET_LIMIT     = 2000;
  localparam longint D_MAX           = (longint'(1) << (D_W - 1)) - 1;
  localparam longint D_MIN           = -(longint'(1) << (D_W - 1));

  typedef enum logic [CFG_AW-1:0] {
    REG_POS_ALPHA,
    REG_ANG_ALPHA,
    REG_VEL_ALPHA,
    REG_ANG_VEL_ALPHA,
    REG_ACC_ALPHA,
    REG_ANG_ACC_ALPHA,
    REG_SPARE6,
    REG_SPARE7
  } reg_idx_t;

  typedef enum int {
    SET_ONE,
    SET_ZERO,
    SET_OVER,
    SET_RAND_IN,
    SET_RAND_ALL,
    SET_MIXED
  } alpha_set_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we;
  logic [CFG_AW-1:0]   cfg_addr;
  logic [ALPHA_W-1:0]  cfg_wdata;

  emt_stream_if #(.payload_t(meas_t))   in_ch ();
  emt_stream_if #(.payload_t(result_t)) out_ch ();

  ema_motion_tracker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // tracker shadow: alphas and per-axis history (x, y, angle)
  longint  alpha_sh [N_ALPHAS] = '{longint'(POS_ALPHA_RST), longint'(POS_ALPHA_RST),
                                   longint'(DER_ALPHA_RST), longint'(DER_ALPHA_RST),
                                   longint'(DER_ALPHA_RST), longint'(DER_ALPHA_RST)};
  cnt_t    samples_seen = CNT_NONE;
  longint  hist_filt [3] = '{0, 0, 0};
  longint  hist_raw  [3] = '{0, 0, 0};
  longint  hist_rvel [3] = '{0, 0, 0};
  longint  hist_vel  [3] = '{0, 0, 0};
  longint  hist_acc  [3] = '{0, 0, 0};

  meas_t   pending_meas [$];
  result_t due_results  [$];

  bit      tx_idle_on;
  bit      rx_idle_on;
  int      tx_gap;
  bit      tx_next;
  int      rx_gap;
  int      rx_hold;
  int      holds_asked;
  int      holds_given;
  int      err_count;
  int      out_beats;
  int      quiet_cycles;
  result_t want_res;
  result_t got_res;

  alpha_set_t phase_plan [8] = '{SET_ZERO, SET_OVER, SET_RAND_IN, SET_MIXED,
                                 SET_RAND_ALL, SET_RAND_IN, SET_MIXED, SET_ONE};

  function automatic longint clamp_d(input longint v);
    if (v > D_MAX) return D_MAX;
    if (v < D_MIN) return D_MIN;
    return v;
  endfunction

  function automatic longint div_floor(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint turn_wrap(input longint v);
    longint r;
    r = v % longint'(ANGLE_TURN);
    if (r < 0) r = r + ANGLE_TURN;
    return r;
  endfunction

  // shortest signed step, in (-turn/2, turn/2]
  function automatic longint turn_delta(input longint from_a, input longint to_a);
    longint d;
    d = to_a - from_a;
    if (2 * d > ANGLE_TURN) d = d - ANGLE_TURN;
    else if (2 * d <= -ANGLE_TURN) d = d + ANGLE_TURN;
    return d;
  endfunction

  function automatic longint smooth(input longint alpha, input longint nv, input longint ov);
    longint w;
    w = (alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : alpha;
    return div_floor(w * nv + (ALPHA_ONE - w) * ov + ALPHA_ONE / 2, ALPHA_ONE);
  endfunction

  function automatic result_t advance_tracker(input meas_t m);
    longint  raw [3];
    longint  f [3];
    longint  v [3];
    longint  a [3];
    longint  rv [3];
    longint  p [3];
    longint  va;
    longint  aa;
    int      i;
    result_t r;
    raw[0] = longint'($signed(m.meas_x));
    raw[1] = longint'($signed(m.meas_y));
    raw[2] = turn_wrap(longint'($signed(m.meas_angle)));
    if (samples_seen == CNT_NONE) begin
      for (i = 0; i < 3; i++) begin
        f[i]  = raw[i];
        v[i]  = 0;
        a[i]  = 0;
        rv[i] = 0;
      end
    end else begin
      f[0]  = smooth(alpha_sh[REG_POS_ALPHA], raw[0], hist_filt[0]);
      f[1]  = smooth(alpha_sh[REG_POS_ALPHA], raw[1], hist_filt[1]);
      f[2]  = smooth(alpha_sh[REG_ANG_ALPHA], raw[2], hist_filt[2]);
      rv[0] = clamp_d(raw[0] - hist_raw[0]);
      rv[1] = clamp_d(raw[1] - hist_raw[1]);
      rv[2] = turn_delta(hist_raw[2], raw[2]);
      for (i = 0; i < 3; i++) begin
        if (samples_seen == CNT_ONE) begin
          v[i] = rv[i];
          a[i] = 0;
        end else begin
          va   = (i < 2) ? alpha_sh[REG_VEL_ALPHA] : alpha_sh[REG_ANG_VEL_ALPHA];
          aa   = (i < 2) ? alpha_sh[REG_ACC_ALPHA] : alpha_sh[REG_ANG_ACC_ALPHA];
          v[i] = clamp_d(smooth(va, rv[i], hist_vel[i]));
          a[i] = clamp_d(smooth(aa, rv[i] - hist_rvel[i], hist_acc[i]));
        end
      end
    end
    for (i = 0; i < 3; i++) begin
      hist_filt[i] = f[i];
      hist_raw[i]  = raw[i];
      hist_rvel[i] = rv[i];
      hist_vel[i]  = v[i];
      hist_acc[i]  = a[i];
    end
    samples_seen = (samples_seen == CNT_NONE) ? CNT_ONE : CNT_MANY;
    // f + v + a/2, half rounded up; a is zero on the second sample
    for (i = 0; i < 3; i++) begin
      p[i] = (samples_seen == CNT_ONE) ? f[i] : div_floor(2 * f[i] + 2 * v[i] + a[i] + 1, 2);
    end
    r.filt_x     = D_W'(f[0]);
    r.filt_y     = D_W'(f[1]);
    r.filt_angle = D_W'(f[2]);
    r.vel_x      = D_W'(v[0]);
    r.vel_y      = D_W'(v[1]);
    r.vel_ang    = D_W'(v[2]);
    r.acc_x      = D_W'(a[0]);
    r.acc_y      = D_W'(a[1]);
    r.acc_ang    = D_W'(a[2]);
    r.pred_x     = D_W'(clamp_d(p[0]));
    r.pred_y     = D_W'(clamp_d(p[1]));
    r.pred_angle = ANG_W'(turn_wrap(p[2]));
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [D_W-1:0] want,
                                      input logic [D_W-1:0] got);
    if (got !== want) begin
      err_count++;
      if (err_count <= 10)
        $display("tb_top: beat %0d %s expected %0d got %0d", out_beats, name,
                 $signed(want), $signed(got));
    end
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int jitter(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // input side: offers the head of the measurement queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        due_results.push_back(advance_tracker(pending_meas.pop_front()));
        tx_gap = tx_idle_on ? pick_gap() : 0;
      end
      if (tx_gap > 0) begin
        tx_gap--;
        tx_next = 1'b0;
      end else begin
        tx_next = (pending_meas.size() != 0);
      end
      in_ch.valid <= tx_next;
      if (tx_next) in_ch.data <= pending_meas[0];
    end
  end

  // result side: checks each beat, then decides ready for the next cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_gap  = 0;
      rx_hold = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_res = out_ch.data;
        if (due_results.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("tb_top: beat %0d arrived with none pending", out_beats);
        end else begin
          want_res = due_results.pop_front();
          check_field("filt_x", want_res.filt_x, got_res.filt_x);
          check_field("filt_y", want_res.filt_y, got_res.filt_y);
          check_field("filt_angle", want_res.filt_angle, got_res.filt_angle);
          check_field("vel_x", want_res.vel_x, got_res.vel_x);
          check_field("vel_y", want_res.vel_y, got_res.vel_y);
          check_field("vel_ang", want_res.vel_ang, got_res.vel_ang);
          check_field("acc_x", want_res.acc_x, got_res.acc_x);
          check_field("acc_y", want_res.acc_y, got_res.acc_y);
          check_field("acc_ang", want_res.acc_ang, got_res.acc_ang);
          check_field("pred_x", want_res.pred_x, got_res.pred_x);
          check_field("pred_y", want_res.pred_y, got_res.pred_y);
          check_field("pred_angle", D_W'(want_res.pred_angle), D_W'(got_res.pred_angle));
        end
        out_beats++;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ch.ready <= 1'b0;
      end else if (holds_given != holds_asked) begin
        // long back-pressure so the pipeline fills and stalls its input
        holds_given++;
        rx_hold = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        rx_gap = rx_idle_on ? pick_gap() : 0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  task automatic queue_meas(input longint x, input longint y, input longint ang);
    meas_t m;
    m.meas_x     = D_W'(x);
    m.meas_y     = D_W'(y);
    m.meas_angle = D_W'(ang);
    pending_meas.push_back(m);
  endtask

  // smooth track with slowly changing velocity; a broken one jumps once
  task automatic queue_track(input int len, input bit broken);
    longint px, py, pa, vx, vy, va, ax, ay, aa;
    int     k;
    int     cut;
    px  = jitter(4000000);
    py  = jitter(4000000);
    pa  = $urandom_range(0, ANGLE_TURN - 1);
    vx  = jitter(3000);
    vy  = jitter(3000);
    va  = jitter(4000);
    ax  = jitter(40);
    ay  = jitter(40);
    aa  = jitter(60);
    cut = broken ? $urandom_range(1, len - 1) : len;
    for (k = 0; k < len; k++) begin
      if (k == cut) begin
        px = px + jitter(8000000);
        py = py + jitter(8000000);
        pa = pa + jitter(40000);
      end
      queue_meas(px + jitter(3), py + jitter(3), turn_wrap(pa) + ANGLE_TURN * jitter(3));
      px = px + vx;
      py = py + vy;
      pa = pa + va;
      vx = vx + ax;
      vy = vy + ay;
      va = va + aa;
    end
  endtask

  task automatic queue_random(input int count);
    int left;
    int len;
    int roll;
    int k;
    left = count;
    while (left > 0) begin
      len  = $urandom_range(6, 30);
      if (len > left) len = left;
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        queue_track(len, 1'b0);
      end else if (roll < 88) begin
        queue_track(len, 1'b1);
      end else begin
        for (k = 0; k < len; k++) queue_meas($urandom, $urandom, $urandom);
      end
      left = left - len;
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [ALPHA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    if (idx <= REG_ANG_ACC_ALPHA) alpha_sh[idx] = longint'(val);
  endtask

  task automatic apply_alpha_set(input alpha_set_t kind);
    logic [ALPHA_W-1:0] val;
    int                 i;
    for (i = 0; i < N_ALPHAS; i++) begin
      case (kind)
        SET_ONE:      val = ALPHA_W'(ALPHA_ONE);
        SET_ZERO:     val = '0;
        SET_OVER:     val = '1;
        SET_RAND_IN:  val = ALPHA_W'($urandom_range(0, ALPHA_ONE));
        SET_RAND_ALL: val = ALPHA_W'($urandom);
        default: begin
          case ($urandom_range(0, 5))
            0:       val = '0;
            1:       val = ALPHA_W'(1);
            2:       val = ALPHA_W'(ALPHA_ONE - 1);
            3:       val = ALPHA_W'(ALPHA_ONE);
            4:       val = ALPHA_W'(ALPHA_ONE + 1);
            default: val = ALPHA_W'($urandom_range(0, 2000));
          endcase
        end
      endcase
      write_reg(reg_idx_t'(i), val);
    end
    // unmapped indexes must leave every alpha alone
    write_reg(REG_SPARE6, ALPHA_W'($urandom));
    write_reg(REG_SPARE7, ALPHA_W'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_meas.size() != 0 || due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  initial begin
    int ph;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset weights: first sample, second sample, half-turn steps, angle wrapping
    @(negedge clk);
    queue_meas(0, 0, 0);
    queue_meas(D_MAX, D_MIN, ANGLE_TURN / 2);
    queue_meas(D_MIN, D_MAX, 0);
    queue_meas(D_MIN, D_MAX, -1);
    queue_meas(0, 0, ANGLE_TURN);
    queue_meas(D_MAX, D_MAX, D_MAX);
    queue_meas(D_MIN, D_MIN, D_MIN);
    queue_meas(-1, 1, ANGLE_TURN - 1);
    queue_meas(256, -256, -ANGLE_TURN);
    queue_meas(1, -1, ANGLE_TURN / 2 + 1);
    queue_meas(D_MAX, D_MIN, 1);
    queue_meas(D_MAX, D_MIN, 1);
    wait_drained();

    // unit weights: full-scale swings saturate velocity, acceleration, prediction
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    apply_alpha_set(SET_ONE);
    @(negedge clk);
    queue_meas(D_MIN, D_MAX, 0);
    queue_meas(D_MAX, D_MIN, ANGLE_TURN / 2);
    queue_meas(D_MIN, D_MAX, 0);
    queue_meas(D_MAX, D_MIN, ANGLE_TURN / 2);
    queue_meas(0, 0, 0);
    queue_meas(D_MAX, D_MAX, ANGLE_TURN - 1);
    queue_meas(D_MAX, D_MAX, ANGLE_TURN - 1);
    queue_meas(D_MIN, D_MIN, D_MIN);
    wait_drained();

    for (ph = 0; ph < 8; ph++) begin
      tx_idle_on = ph[0];
      rx_idle_on = ph[1];
      apply_alpha_set(phase_plan[ph]);
      if (ph == 1 || ph == 5) tx_idle_on = 1'b0;
      @(negedge clk);
      queue_random(ITEMS_PER_PHASE);
      if (ph == 1 || ph == 5) holds_asked++;
      wait_drained();
    end

    if (err_count == 0 && due_results.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* ema_motion_tracker.f */
design/emt_pkg.sv
design/emt_stream_if.sv
design/emt_diff.sv
design/emt_filter.sv
design/ema_motion_tracker.sv
design/emt_checker.sv
bench/tb_top.sv
